// ----- sv/stkrm_pkg.sv -----
// Shared types, codes and constants of the stack with remove by value.
`default_nettype none

package stkrm_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int DATA_W          = 32;
    localparam int DEPTH_W         = 5;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_WAIT,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  popped_value;
        logic [DEPTH_W-1:0]        depth_now;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/stack_with_remove_by_value.sv -----
// Top level of the LIFO stack with push, pop and remove by value.
// A LIFO stack of signed 32-bit words, STACK_DEPTH deep, held in one
// single-port-write, registered-read memory. Each request gives exactly one
// result with a status and the depth afterward. Push and the unused command
// code go from accept straight to the result state; pop first waits for the
// memory read, unless the stack is empty. Remove first compares entries from
// the top down (one per cycle through the memory read port) and then moves
// the entries above the match down (one per cycle, read and write port
// together). A new request is taken only once the previous one has handed
// its result to the output register, which holds it until the downstream
// side takes it. No clearing pass after reset.
`default_nettype none

module stack_with_remove_by_value #(
    parameter int STACK_DEPTH = stkrm_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic [1:0]                            i_cmd,
    input  wire logic signed [stkrm_pkg::DATA_W-1:0]   i_operand_value,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic [1:0]                                 o_status,
    output logic signed [stkrm_pkg::DATA_W-1:0]        o_popped_value,
    output logic [stkrm_pkg::DEPTH_W-1:0]              o_depth_now
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [stkrm_pkg::DEPTH_W-1:0] FULL_DEPTH =
        stkrm_pkg::DEPTH_W'(STACK_DEPTH);

    logic                                mem_we;
    logic [AW-1:0]                       mem_waddr;
    logic signed [stkrm_pkg::DATA_W-1:0] mem_wdata;
    logic                                mem_re;
    logic [AW-1:0]                       mem_raddr;
    logic signed [stkrm_pkg::DATA_W-1:0] mem_rdata;

    logic               res_valid;
    logic               slot_free;
    logic               res_load;
    stkrm_pkg::t_result res;
    stkrm_pkg::t_result r_out;
    logic               r_out_valid;

    assign slot_free = !r_out_valid || i_ready;
    assign res_load  = res_valid && slot_free;

    stkrm_seq #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .o_req_ready     (o_ready),
        .i_cmd           (i_cmd),
        .i_operand_value (i_operand_value),
        .o_res_valid     (res_valid),
        .i_res_ready     (slot_free),
        .o_res           (res),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr),
        .i_mem_rdata     (mem_rdata)
    );

    stkrm_mem #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_popped_value = r_out.popped_value;
    assign o_depth_now    = r_out.depth_now;

    a_empty_depth : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load && (res.status == stkrm_pkg::ST_EMPTY) |-> (res.depth_now == '0))
        else $error("empty result with nonzero depth");

    a_full_depth : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load && (res.status == stkrm_pkg::ST_FULL) |-> (res.depth_now == FULL_DEPTH))
        else $error("full result below capacity");

    a_popped_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load && (res.popped_value != '0) |-> (res.status == stkrm_pkg::ST_OK))
        else $error("value returned with failing status");

    a_no_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !res_valid)
        else $error("request taken while a result is pending");

endmodule

`default_nettype wire

// ----- sv/stkrm_mem.sv -----
// Stack storage: one write port, one read port with registered read data.
`default_nettype none

module stkrm_mem #(
    parameter int STACK_DEPTH = stkrm_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [$clog2(STACK_DEPTH)-1:0]        i_waddr,
    input  wire logic signed [stkrm_pkg::DATA_W-1:0]   i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [$clog2(STACK_DEPTH)-1:0]        i_raddr,
    output logic signed [stkrm_pkg::DATA_W-1:0]        o_rdata
);

    logic signed [stkrm_pkg::DATA_W-1:0] r_mem [STACK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/stkrm_seq.sv -----
// Command sequencer: push, pop and remove by scan and shift over the storage.
`default_nettype none

module stkrm_seq #(
    parameter int STACK_DEPTH = stkrm_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_req_valid,
    output logic                                       o_req_ready,
    input  wire logic [1:0]                            i_cmd,
    input  wire logic signed [stkrm_pkg::DATA_W-1:0]   i_operand_value,
    output logic                                       o_res_valid,
    input  wire logic                                  i_res_ready,
    output stkrm_pkg::t_result                         o_res,
    output logic                                       o_mem_we,
    output logic [$clog2(STACK_DEPTH)-1:0]             o_mem_waddr,
    output logic signed [stkrm_pkg::DATA_W-1:0]        o_mem_wdata,
    output logic                                       o_mem_re,
    output logic [$clog2(STACK_DEPTH)-1:0]             o_mem_raddr,
    input  wire logic signed [stkrm_pkg::DATA_W-1:0]   i_mem_rdata
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

    stkrm_pkg::t_state r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    logic signed [stkrm_pkg::DATA_W-1:0] r_val, n_val;
    stkrm_pkg::t_status r_status, n_status;
    logic signed [stkrm_pkg::DATA_W-1:0] r_popped, n_popped;

    logic            accept;
    logic [CW-1:0]   cnt_m1;
    logic [CW-1:0]   idx_ext;
    logic [CW-1:0]   idx_p1;
    logic [CW-1:0]   idx_p2;
    logic            match;
    logic            at_top;
    logic            last_shift;
    logic [CW+4:0]   cnt_ext;

    assign accept     = i_req_valid && (r_state == stkrm_pkg::S_IDLE);
    assign cnt_m1     = r_count - 1'b1;
    assign idx_ext    = CW'(r_idx);
    assign idx_p1     = idx_ext + CW'(1);
    assign idx_p2     = idx_ext + CW'(2);
    assign match      = (i_mem_rdata == r_val);
    assign at_top     = (idx_ext == cnt_m1);
    assign last_shift = (idx_p1 == cnt_m1);
    assign cnt_ext    = (CW + 5)'(r_count);

    assign o_req_ready = (r_state == stkrm_pkg::S_IDLE);
    assign o_res_valid = (r_state == stkrm_pkg::S_DONE);
    assign o_res.status       = r_status;
    assign o_res.popped_value = r_popped;
    assign o_res.depth_now    = cnt_ext[stkrm_pkg::DEPTH_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            stkrm_pkg::S_IDLE: begin
                if (accept) begin
                    case (stkrm_pkg::t_cmd'(i_cmd))
                        stkrm_pkg::CMD_POP: begin
                            n_state = (r_count == '0) ? stkrm_pkg::S_DONE
                                                      : stkrm_pkg::S_POP_WAIT;
                        end
                        stkrm_pkg::CMD_REMOVE: begin
                            n_state = (r_count == '0) ? stkrm_pkg::S_DONE
                                                      : stkrm_pkg::S_SCAN;
                        end
                        default: begin
                            n_state = stkrm_pkg::S_DONE;
                        end
                    endcase
                end
            end
            stkrm_pkg::S_POP_WAIT: begin
                n_state = stkrm_pkg::S_DONE;
            end
            stkrm_pkg::S_SCAN: begin
                if (match) begin
                    n_state = at_top ? stkrm_pkg::S_DONE : stkrm_pkg::S_SHIFT;
                end else if (r_idx == '0) begin
                    n_state = stkrm_pkg::S_DONE;
                end
            end
            stkrm_pkg::S_SHIFT: begin
                if (last_shift) begin
                    n_state = stkrm_pkg::S_DONE;
                end
            end
            stkrm_pkg::S_DONE: begin
                if (i_res_ready) begin
                    n_state = stkrm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stkrm_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_val       = r_val;
        n_status    = r_status;
        n_popped    = r_popped;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx;
        case (r_state)
            stkrm_pkg::S_IDLE: begin
                if (accept) begin
                    n_status = stkrm_pkg::ST_OK;
                    n_popped = '0;
                    n_val    = i_operand_value;
                    case (stkrm_pkg::t_cmd'(i_cmd))
                        stkrm_pkg::CMD_PUSH: begin
                            if (r_count == FULL_CNT) begin
                                n_status = stkrm_pkg::ST_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_count[AW-1:0];
                                o_mem_wdata = i_operand_value;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        stkrm_pkg::CMD_POP: begin
                            if (r_count == '0) begin
                                n_status = stkrm_pkg::ST_EMPTY;
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = cnt_m1[AW-1:0];
                                n_count     = cnt_m1;
                            end
                        end
                        stkrm_pkg::CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = stkrm_pkg::ST_NOTFOUND;
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = cnt_m1[AW-1:0];
                                n_idx       = cnt_m1[AW-1:0];
                            end
                        end
                        default: begin
                            n_status = stkrm_pkg::ST_OK;
                        end
                    endcase
                end
            end
            stkrm_pkg::S_POP_WAIT: begin
                n_popped = i_mem_rdata;
            end
            stkrm_pkg::S_SCAN: begin
                if (match) begin
                    if (at_top) begin
                        n_count = cnt_m1;
                    end else begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = idx_p1[AW-1:0];
                    end
                end else if (r_idx == '0) begin
                    n_status = stkrm_pkg::ST_NOTFOUND;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_idx - 1'b1;
                    n_idx       = r_idx - 1'b1;
                end
            end
            stkrm_pkg::S_SHIFT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx;
                o_mem_wdata = i_mem_rdata;
                if (last_shift) begin
                    n_count = cnt_m1;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = idx_p2[AW-1:0];
                    n_idx       = idx_p1[AW-1:0];
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stkrm_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_status <= n_status;
        r_popped <= n_popped;
    end

endmodule

`default_nettype wire

// ----- tb/stack_with_remove_by_value_test.sv -----
// Self-checking testbench for the stack with push, pop and remove by value.
`timescale 1ns / 1ps

module stack_with_remove_by_value_test;
    import stkrm_pkg::*;

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [1:0]                 i_cmd = CMD_PUSH;
    logic signed [DATA_W-1:0]   i_operand_value = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [1:0]                 o_status;
    logic signed [DATA_W-1:0]   o_popped_value;
    logic [DEPTH_W-1:0]         o_depth_now;

    logic signed [DATA_W-1:0]   model_words [STACK_DEPTH];
    int                         model_count = 0;
    t_result                    pending_results [$];
    int                         err_count = 0;
    bit                         tx_idle_en = 1'b1;
    bit                         rx_idle_en = 1'b1;
    int                         rx_hold_cycles = 0;

    stack_with_remove_by_value #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_operand_value(i_operand_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_depth_now    (o_depth_now)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("** stack_with_remove_by_value: FAILED **");
        $finish;
    end

    function automatic t_result apply_stack_op(input logic [1:0] cmd,
                                               input logic signed [DATA_W-1:0] val);
        t_result res;
        int      pos;
        res.status       = ST_OK;
        res.popped_value = '0;
        pos              = -1;
        case (cmd)
            CMD_PUSH: begin
                if (model_count >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    model_words[model_count] = val;
                    model_count++;
                end
            end
            CMD_POP: begin
                if (model_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    model_count--;
                    res.popped_value = model_words[model_count];
                end
            end
            CMD_REMOVE: begin
                for (int k = model_count - 1; k >= 0; k--) begin
                    if (model_words[k] == val) begin
                        pos = k;
                        break;
                    end
                end
                if (pos < 0) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    for (int k = pos; k < model_count - 1; k++)
                        model_words[k] = model_words[k + 1];
                    model_count--;
                end
            end
            default: ;
        endcase
        res.depth_now = DEPTH_W'(model_count);
        return res;
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 19) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_cmd           <= cmd;
        i_operand_value <= val;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(apply_stack_op(cmd, val));
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_push_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return pick_extreme();
        if (r <= 5)
            return $urandom_range(0, 11) - 6;
        return $urandom;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_search_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55 && model_count > 0)
            return model_words[$urandom_range(0, model_count - 1)];
        if (r < 80)
            return $urandom_range(0, 11) - 6;
        if (r < 85)
            return pick_extreme();
        return $urandom;
    endfunction

    task automatic send_random(input int push_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            send_request(CMD_UNUSED, $urandom);
        else if (r < 3 + push_weight)
            send_request(CMD_PUSH, pick_push_value());
        else if (r < 3 + push_weight + (97 - push_weight) / 2)
            send_request(CMD_POP, $urandom);
        else
            send_request(CMD_REMOVE, pick_search_value());
    endtask

    task automatic test_empty_stack();
        send_request(CMD_POP, 32'h1234_5678);
        send_request(CMD_REMOVE, 32'h0000_0000);
        send_request(CMD_UNUSED, 32'hFFFF_FFFF);
    endtask

    task automatic test_fill_and_overflow();
        logic signed [DATA_W-1:0] fill [16];
        fill = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                 7, 7, 32'hAAAA_AAAA, 32'h5555_5555, 7, 3, 12345, -12345,
                 32'h0000_FFFF, 32'hFFFF_0000, 7, 100};
        foreach (fill[k])
            send_request(CMD_PUSH, fill[k]);
        send_request(CMD_PUSH, 42);
    endtask

    task automatic test_remove_cases();
        send_request(CMD_REMOVE, 7);
        send_request(CMD_REMOVE, 999);
        send_request(CMD_REMOVE, 32'h8000_0000);
        send_request(CMD_REMOVE, 100);
        send_request(CMD_POP, 32'h0);
    endtask

    task automatic test_random_traffic(input int count);
        int push_weight;
        push_weight = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) begin
                push_weight = $urandom_range(20, 70);
                tx_idle_en  = ($urandom_range(0, 3) != 0);
                rx_idle_en  = ($urandom_range(0, 3) != 0);
            end
            send_random(push_weight);
        end
    endtask

    task automatic test_output_stall();
        tx_idle_en = 1'b0;
        for (int round = 0; round < 4; round++) begin
            rx_hold_cycles = 60 + $urandom_range(0, 40);
            for (int n = 0; n < 20; n++)
                send_random(50);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_drain_pause();
        for (int round = 0; round < 3; round++) begin
            for (int n = 0; n < 20; n++)
                send_random(45);
            wait_results_drained();
        end
    endtask

    initial begin : receiver
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                gap = rx_idle_en ? $urandom_range(0, 19) : 0;
            end
            @(negedge i_clk);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d value %0d depth %0d",
                       o_status, o_popped_value, o_depth_now);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    err_count++;
                end
                if (o_popped_value !== want.popped_value) begin
                    $error("popped_value: expected %0d, got %0d",
                           want.popped_value, o_popped_value);
                    err_count++;
                end
                if (o_depth_now !== want.depth_now) begin
                    $error("depth_now: expected %0d, got %0d", want.depth_now, o_depth_now);
                    err_count++;
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_stack();
        test_fill_and_overflow();
        test_remove_cases();
        test_random_traffic(1500);
        test_output_stall();
        test_drain_pause();

        wait_results_drained();
        repeat (40) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("** stack_with_remove_by_value: PASSED **");
        end else begin
            $display("** stack_with_remove_by_value: FAILED **");
        end
        $finish;
    end

endmodule
